/* design/skri_pkg.sv */
// shared types and constants for the sorted key reference index
// used by skri_cell, skri_grp and sorted_key_reference_index
`default_nettype none

package skri_pkg;

    localparam int KEY_W    = 32;
    localparam int REF_W    = 64;
    localparam int RANK_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int GRP_SIZE = 16;
    localparam int GRP_IW   = $clog2(GRP_SIZE);

    // request kinds
    typedef enum logic [1:0] {
        FUNC_FIND   = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_UPDATE = 2'd3
    } func_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_PRESENT   = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // edit broadcast to every cell of the row
    typedef struct packed {
        logic insert;
        logic remove;
        logic update;
    } cell_cmd_t;

    // partial lookup result of one group of cells
    typedef struct packed {
        logic              found;
        logic [RANK_W-1:0] rank;
        logic [REF_W-1:0]  ref_val;
    } grp_res_t;

endpackage

`default_nettype wire

/* design/skri_cell.sv */
// one entry of the sorted row: holds a key and its reference, compares
// against the broadcast key and shifts with its neighbours; uses skri_pkg
`default_nettype none

module skri_cell (
    input  wire logic                          clk,
    input  wire logic                          cmp_en,
    input  wire skri_pkg::cell_cmd_t           cmd,
    input  wire logic                          valid,
    input  wire logic [skri_pkg::KEY_W-1:0]    req_key,
    input  wire logic [skri_pkg::REF_W-1:0]    req_ref,
    input  wire logic                          prev_lt,
    input  wire logic [skri_pkg::KEY_W-1:0]    prev_key,
    input  wire logic [skri_pkg::REF_W-1:0]    prev_ref,
    input  wire logic [skri_pkg::KEY_W-1:0]    next_key,
    input  wire logic [skri_pkg::REF_W-1:0]    next_ref,
    output logic [skri_pkg::KEY_W-1:0]         cell_key,
    output logic [skri_pkg::REF_W-1:0]         cell_ref,
    output logic                               lt,
    output logic                               bnd,
    output logic                               eq
);

    logic [skri_pkg::KEY_W-1:0] key_reg;
    logic [skri_pkg::REF_W-1:0] ref_reg;
    logic                       lt_reg;
    logic                       bnd_reg;
    logic                       eq_reg;

    // signed compare against the broadcast key
    always_comb
    begin
        lt  = valid && ($signed(key_reg) < $signed(req_key));
        eq  = valid && (key_reg == req_key);
        bnd = !lt && prev_lt;
    end

    // hold compare flags and apply the edit of the transaction
    always_ff @(posedge clk)
    begin
        if (cmp_en)
        begin
            lt_reg  <= lt;
            bnd_reg <= bnd;
            eq_reg  <= eq;
        end
        priority if (cmd.insert && !lt_reg)
        begin
            if (bnd_reg)
            begin
                key_reg <= req_key;
                ref_reg <= req_ref;
            end
            else
            begin
                key_reg <= prev_key;
                ref_reg <= prev_ref;
            end
        end
        else if (cmd.remove && !lt_reg)
        begin
            key_reg <= next_key;
            ref_reg <= next_ref;
        end
        else if (cmd.update && eq_reg)
        begin
            ref_reg <= req_ref;
        end
    end

    assign cell_key = key_reg;
    assign cell_ref = ref_reg;

endmodule

`default_nettype wire

/* design/skri_grp.sv */
// reduces the compare flags of one group of cells to a registered
// found flag, rank and reference; uses skri_pkg
`default_nettype none

module skri_grp (
    input  wire logic                                                 clk,
    input  wire logic                                                 en,
    input  wire logic [skri_pkg::RANK_W-1:0]                          base,
    input  wire logic [skri_pkg::GRP_SIZE-1:0]                        bnd,
    input  wire logic [skri_pkg::GRP_SIZE-1:0]                        eq,
    input  wire logic [skri_pkg::GRP_SIZE-1:0][skri_pkg::REF_W-1:0]   refs,
    output skri_pkg::grp_res_t                                        res
);

    skri_pkg::grp_res_t           res_reg;
    skri_pkg::grp_res_t           res_next;
    logic [skri_pkg::GRP_IW-1:0]  rank_lo;

    // or-reduce the one-hot boundary and match flags
    always_comb
    begin
        rank_lo          = '0;
        res_next.found   = 1'b0;
        res_next.ref_val = '0;
        for (int j = 0; j < skri_pkg::GRP_SIZE; j++)
        begin
            if (bnd[j])
            begin
                rank_lo = rank_lo | skri_pkg::GRP_IW'(j);
            end
            if (eq[j])
            begin
                res_next.found   = 1'b1;
                res_next.ref_val = res_next.ref_val | refs[j];
            end
        end
        res_next.rank = (|bnd) ? (base | skri_pkg::RANK_W'(rank_lo)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* design/sorted_key_reference_index.sv */
// Sorted key reference index: a row of CAPACITY cells holding unique signed
// keys in ascending order, each with a 64-bit reference.
// Requests arrive on the s_axis channel (tuser = request kind, tdata = key
// and reference). Each request is find, add, remove or update. One result
// per request leaves on the m_axis channel (tuser = status, tdata = rank,
// stored reference and entry count after the request).
// Sequence: the request is registered on acceptance in S_IDLE; in S_CMP
// every cell compares the key at once and the flags are reduced and
// registered in groups of 16 cells; S_APPLY merges the groups and, once the
// output register is free or being read, shifts the row for add or remove
// and loads the output register. A new request is taken only in S_IDLE,
// after the previous request has been applied.
// The output register lets the next request be taken while a result waits;
// that request then stops before its edit until the result is taken, so a
// stall on m_axis back-pressures s_axis through s_axis_tready.
// Reset empties the table at once (entry count zero); cell contents are
// not cleared and are never read before they are written.
`default_nettype none

module sorted_key_reference_index #(
    parameter int CAPACITY = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [95:0]   s_axis_tdata,   // key [31:0], ref_in [95:32]
    input  wire logic [1:0]    s_axis_tuser,   // func [1:0]
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [87:0]        m_axis_tdata,   // rank [7:0], ref_out [71:8],
                                               // entry_count [80:72], zero pad
    output logic [1:0]         m_axis_tuser    // status [1:0]
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int NGRP = (CAPACITY + skri_pkg::GRP_SIZE - 1) / skri_pkg::GRP_SIZE;
    localparam int NPAD = NGRP * skri_pkg::GRP_SIZE;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    skri_pkg::func_t                 req_func_reg;
    logic [skri_pkg::KEY_W-1:0]      req_key_reg;
    logic [skri_pkg::REF_W-1:0]      req_ref_reg;
    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;

    logic                            out_valid_reg;
    skri_pkg::status_t               out_status_reg;
    skri_pkg::status_t               out_status_next;
    logic [skri_pkg::RANK_W-1:0]     out_rank_reg;
    logic [skri_pkg::RANK_W-1:0]     out_rank_next;
    logic [skri_pkg::REF_W-1:0]      out_ref_reg;
    logic [skri_pkg::REF_W-1:0]      out_ref_next;
    logic [skri_pkg::COUNT_W-1:0]    out_count_reg;

    logic                            s_accept;
    logic                            apply_go;
    logic                            full;
    logic                            found;
    logic [skri_pkg::RANK_W-1:0]     rank;
    logic [skri_pkg::REF_W-1:0]      found_ref;
    skri_pkg::cell_cmd_t             cmd;

    logic [skri_pkg::KEY_W-1:0]      cell_key [CAPACITY];
    logic [skri_pkg::REF_W-1:0]      cell_ref [CAPACITY];
    logic [CAPACITY-1:0]             lt_vec;
    logic [NPAD-1:0]                 bnd_vec;
    logic [NPAD-1:0]                 eq_vec;
    logic [NPAD-1:0][skri_pkg::REF_W-1:0] ref_pad;
    skri_pkg::grp_res_t              grp_res [NGRP];

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign apply_go = (state_reg == S_APPLY) && (!out_valid_reg || m_axis_tready);
    assign full     = (count_reg == CW'(CAPACITY));

    // sequencer: accept, compare, apply
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (apply_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    // request register
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            req_func_reg <= skri_pkg::func_t'(s_axis_tuser);
            req_key_reg  <= s_axis_tdata[31:0];
            req_ref_reg  <= s_axis_tdata[95:32];
        end
    end

    // row of cells with neighbour links
    for (genvar i = 0; i < NPAD; i++)
    begin : g_cell
        if (i < CAPACITY)
        begin : g_real
            logic                       prev_lt;
            logic [skri_pkg::KEY_W-1:0] prev_key;
            logic [skri_pkg::REF_W-1:0] prev_ref;
            logic [skri_pkg::KEY_W-1:0] next_key;
            logic [skri_pkg::REF_W-1:0] next_ref;

            if (i == 0)
            begin : g_first
                assign prev_lt  = 1'b1;
                assign prev_key = req_key_reg;
                assign prev_ref = req_ref_reg;
            end
            else
            begin : g_mid
                assign prev_lt  = lt_vec[i-1];
                assign prev_key = cell_key[i-1];
                assign prev_ref = cell_ref[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign next_key = cell_key[i];
                assign next_ref = cell_ref[i];
            end
            else
            begin : g_inner
                assign next_key = cell_key[i+1];
                assign next_ref = cell_ref[i+1];
            end

            skri_cell u_cell (
                .clk      (clk),
                .cmp_en   (state_reg == S_CMP),
                .cmd      (cmd),
                .valid    (CW'(i) < count_reg),
                .req_key  (req_key_reg),
                .req_ref  (req_ref_reg),
                .prev_lt  (prev_lt),
                .prev_key (prev_key),
                .prev_ref (prev_ref),
                .next_key (next_key),
                .next_ref (next_ref),
                .cell_key (cell_key[i]),
                .cell_ref (cell_ref[i]),
                .lt       (lt_vec[i]),
                .bnd      (bnd_vec[i]),
                .eq       (eq_vec[i])
            );

            assign ref_pad[i] = cell_ref[i];
        end
        else
        begin : g_pad
            assign bnd_vec[i] = 1'b0;
            assign eq_vec[i]  = 1'b0;
            assign ref_pad[i] = '0;
        end
    end

    // first reduction level, registered per group
    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        skri_grp u_grp (
            .clk  (clk),
            .en   (state_reg == S_CMP),
            .base (skri_pkg::RANK_W'(g * skri_pkg::GRP_SIZE)),
            .bnd  (bnd_vec[g*skri_pkg::GRP_SIZE +: skri_pkg::GRP_SIZE]),
            .eq   (eq_vec[g*skri_pkg::GRP_SIZE +: skri_pkg::GRP_SIZE]),
            .refs (ref_pad[g*skri_pkg::GRP_SIZE +: skri_pkg::GRP_SIZE]),
            .res  (grp_res[g])
        );
    end

    // merge the group results
    always_comb
    begin
        found     = 1'b0;
        rank      = '0;
        found_ref = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            found     = found | grp_res[g].found;
            rank      = rank | grp_res[g].rank;
            found_ref = found_ref | grp_res[g].ref_val;
        end
    end

    // edit command and result of the transaction
    always_comb
    begin
        cmd             = '0;
        count_next      = count_reg;
        out_status_next = skri_pkg::ST_DONE;
        out_rank_next   = '0;
        out_ref_next    = '0;
        unique case (req_func_reg)
            skri_pkg::FUNC_FIND:
            begin
                if (found)
                begin
                    out_rank_next = rank;
                    out_ref_next  = found_ref;
                end
                else
                begin
                    out_status_next = skri_pkg::ST_NOT_FOUND;
                end
            end
            skri_pkg::FUNC_ADD:
            begin
                priority if (found)
                begin
                    out_status_next = skri_pkg::ST_PRESENT;
                    out_rank_next   = rank;
                    out_ref_next    = found_ref;
                end
                else if (full)
                begin
                    out_status_next = skri_pkg::ST_FULL;
                end
                else
                begin
                    cmd.insert    = apply_go;
                    count_next    = count_reg + CW'(1);
                    out_rank_next = rank;
                    out_ref_next  = req_ref_reg;
                end
            end
            skri_pkg::FUNC_REMOVE:
            begin
                if (found)
                begin
                    cmd.remove = apply_go;
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    out_status_next = skri_pkg::ST_NOT_FOUND;
                end
            end
            skri_pkg::FUNC_UPDATE:
            begin
                if (found)
                begin
                    cmd.update    = apply_go;
                    out_rank_next = rank;
                    out_ref_next  = req_ref_reg;
                end
                else
                begin
                    out_status_next = skri_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                out_status_next = skri_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // entry count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (apply_go)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (apply_go)
        begin
            out_status_reg <= out_status_next;
            out_rank_reg   <= out_rank_next;
            out_ref_reg    <= out_ref_next;
            out_count_reg  <= skri_pkg::COUNT_W'(count_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {7'd0, out_count_reg, out_ref_reg, out_rank_reg};

endmodule

`default_nettype wire
